// ----- rtl/stable_priority_event_queue_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority event queue
// Shared shorthand for the concurrent checks of the queue's ports.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_EVENT_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_EVENT_QUEUE_TOP_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define SPQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("queue port check failed");

// Clocked check that also holds while reset is asserted.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("queue port check failed");

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable priority event queue package
// Sizes, codes and beat types shared by the queue, its cells and its checker.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 4;
	localparam int TAG_BITS      = 8;
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

	// Request kinds.
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic                     req_type;
		logic [TAG_BITS-1:0]      event_tag;
		logic [PRIORITY_BITS-1:0] event_priority;
	} spq_req_t;

	typedef struct packed {
		spq_status_t              status;
		logic [TAG_BITS-1:0]      out_tag;
		logic [PRIORITY_BITS-1:0] out_priority;
		logic                     head_valid;
		logic [PRIORITY_BITS-1:0] head_priority;
		logic [CNT_W-1:0]         entry_count;
	} spq_rsp_t;

	// One stored event.
	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [TAG_BITS-1:0]      tag;
	} spq_entry_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic       ins;
		logic       rem;
		spq_entry_t item;
	} spq_cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Queue cell
// One slot of the sorted chain: keeps, takes the new event, or shifts.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  spq_cmd_t   cmd,
	input  logic       occupied,
	input  logic       left_keep,
	input  spq_entry_t left_entry,
	input  spq_entry_t right_entry,
	output spq_entry_t entry,
	output logic       keep
);

	spq_entry_t entry_q;

	// An occupied slot that is no less urgent than the new event stays put,
	// which places equal priorities behind earlier arrivals.
	assign keep  = occupied && (entry_q.prio <= cmd.item.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!keep) begin
				entry_q <= left_keep ? cmd.item : left_entry;
			end
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ----- rtl/stable_priority_event_queue_top.sv -----
// ----------------------------------------------------------------------------
// Stable priority event queue
// Bounded queue of events kept sorted by priority in a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel | valid     | ready     | payload | direction
//  --------+-----------+-----------+---------+----------
//  request | req_valid | req_ready | req     | in
//  result  | rsp_valid | rsp_ready | rsp     | out
//
// Every request beat yields exactly one result beat, registered in the cycle
// after acceptance. The queue takes one request per cycle while req_ready is
// high: all cells compare against the new priority and shift in the same
// cycle, so no step iterates. A request is taken whenever the result register
// is empty or being drained, so a stalled consumer holds the queue for exactly
// as long as it stalls. Reset clears the entry count and the result valid;
// slot contents are not reset, and only slots below the count are ever shown.
//
module stable_priority_event_queue_top import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  spq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output spq_rsp_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	spq_rsp_t         rsp_q;

	spq_cmd_t         cmd;
	spq_entry_t       ent  [QUEUE_DEPTH];
	logic             keep [QUEUE_DEPTH];
	logic             occ  [QUEUE_DEPTH];

	logic accept;
	logic is_ins;
	logic full;
	logic empty;
	logic do_ins;
	logic do_rem;
	spq_rsp_t rsp_d;
	logic [CNT_W-1:0] count_d;

	// The result register parts the two sides: a new request is taken in the
	// same cycle that the waiting result leaves.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign is_ins = (req.req_type == REQ_INSERT);
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign do_ins = accept && is_ins && !full;
	assign do_rem = accept && !is_ins && !empty;

	assign cmd.ins       = do_ins;
	assign cmd.rem       = do_rem;
	assign cmd.item.prio = req.event_priority;
	assign cmd.item.tag  = req.event_tag;

	// The chain of cells. Slot 0 is the head. On an insert a cell that does not
	// stay takes the new event if its left neighbor stays, else shifts one place
	// right. On a remove every cell takes its right neighbor's entry; the tail keeps its own.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign occ[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			spq_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occ[i]),
				.left_keep   (1'b1),
				.left_entry  (cmd.item),
				.right_entry (ent[i+1]),
				.entry       (ent[i]),
				.keep        (keep[i])
			);
		end else if (i == QUEUE_DEPTH - 1) begin : g_tail
			spq_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occ[i]),
				.left_keep   (keep[i-1]),
				.left_entry  (ent[i-1]),
				.right_entry (ent[i]),
				.entry       (ent[i]),
				.keep        (keep[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (occ[i]),
				.left_keep   (keep[i-1]),
				.left_entry  (ent[i-1]),
				.right_entry (ent[i+1]),
				.entry       (ent[i]),
				.keep        (keep[i])
			);
		end
	end

	// Result for the accepted request, formed from the cells before they move.
	always_comb begin
		rsp_d              = '0;
		count_d            = count_q;
		rsp_d.status       = ST_OK;
		rsp_d.head_priority = empty ? '0 : ent[0].prio;
		if (is_ins) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
				// The new event becomes the head unless the head stays.
				if (empty || !keep[0]) begin
					rsp_d.head_priority = req.event_priority;
				end
			end
		end else begin
			if (empty) begin
				rsp_d.status = ST_EMPTY;
			end else begin
				count_d            = count_q - CNT_W'(1);
				rsp_d.out_tag      = ent[0].tag;
				rsp_d.out_priority = ent[0].prio;
				rsp_d.head_priority = (count_q > CNT_W'(1)) ? ent[1].prio : '0;
			end
		end
		rsp_d.head_valid  = (count_d != '0);
		rsp_d.entry_count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// Queue port checker
// Concurrent checks on the ports of the stable priority event queue.
// ----------------------------------------------------------------------------
`include "stable_priority_event_queue_top_macros.svh"

module spq_checker import spq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input spq_rsp_t rsp
);

	`SPQ_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	`SPQ_ASSERT(a_head_count, clk, arst_n, rsp_valid |-> rsp.head_valid == (rsp.entry_count != '0))
	`SPQ_ASSERT(a_empty_rsp, clk, arst_n, rsp_valid && rsp.status == ST_EMPTY |-> rsp.entry_count == '0 && rsp.out_tag == '0 && rsp.out_priority == '0)
	`SPQ_ASSERT(a_full_rsp, clk, arst_n, rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_W'(QUEUE_DEPTH))
	`SPQ_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !rsp_valid)

endmodule

bind stable_priority_event_queue_top spq_checker u_spq_checker (.*);
